### rtl/mbrx_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mbrx_pkg: shared types and constants for the Modbus RTU receive framer
// Phase and code enums, frame limits, CRC-16 step and the control structs
// passed between the framer control and the top level.
// ---------------------------------------------------------------------------
package mbrx_pkg;

  // Frame limits and storage geometry
  localparam int FRAME_MAX   = 256;
  localparam int FRAME_MIN   = 4;
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 9;

  // Register reset, CRC and silence limit constants
  localparam logic [15:0] T35_RESET = 16'd1800;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] SIL_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_IDLE = 2'd1,
    PH_RCV  = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    EV_BUS_UP = 2'd0,
    EV_FRAME  = 2'd1,
    EV_READ   = 2'd2
  } ev_t;

  // Frame store access issued for one accepted word
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } ram_req_t;

  // Result held while the store read completes
  typedef struct packed {
    logic       valid;
    ev_t        kind;
    logic [7:0] addr;
    logic [7:0] len;
    logic       ok;
  } res_t;

  // One Modbus CRC-16 byte update, reflected polynomial
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/mbrx_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mbrx interfaces: valid/ready channels of the receive framer
// Input word channel, result word channel and configuration write channel.
// ---------------------------------------------------------------------------
interface mbrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [7:0] read_index;
  modport source (output valid, action, rx_byte, read_index, input ready);
  modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

interface mbrx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] slave_address;
  logic [7:0] pdu_length;
  logic       frame_ok;
  logic [7:0] read_data;
  modport source (output valid, event_kind, slave_address, pdu_length, frame_ok,
                  read_data, input ready);
  modport sink   (input valid, event_kind, slave_address, pdu_length, frame_ok,
                  read_data, output ready);
endinterface

interface mbrx_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/modbus_rtu_rx_framer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// modbus_rtu_rx_framer_unit: Modbus RTU receive framer
// Frames received bytes by bus silence, stores them in a frame RAM, tracks
// the CRC and reports bus ready, frame received and buffer read words.
// ---------------------------------------------------------------------------
// A result word goes through the result stage and then the output register.
// Throughput: one input word per cycle unless the result stage stalls; the
//   frame RAM read latency is covered by these stages, so one result may wait unread.
// Reset: synchronous; phase init, timer running, t35_ticks 1800. The frame
//   RAM is not cleared and holds undefined data until written.
module modbus_rtu_rx_framer_unit
  import mbrx_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  mbrx_cfg_if.sink  cfg,
  mbrx_in_if.sink   rx,
  mbrx_out_if.source ev
);

  ram_req_t   ram_req;
  res_t       res;
  res_t       stage;
  logic [7:0] ram_q;
  logic       accept;
  logic       stage_adv;
  logic       out_valid;
  ev_t        out_kind;
  logic [7:0] out_addr;
  logic [7:0] out_len;
  logic       out_ok;
  logic [7:0] out_data;

  assign cfg.ready = 1'b1;

  // Accept while the result stage is empty or draining
  assign stage_adv = stage.valid && (!out_valid || ev.ready);
  assign rx.ready  = !stage.valid || stage_adv;
  assign accept    = rx.valid && rx.ready;

  mbrx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.data),
    .accept     (accept),
    .action     (rx.action),
    .rx_byte    (rx.rx_byte),
    .read_index (rx.read_index),
    .ram_req    (ram_req),
    .res        (res)
  );

  mbrx_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_q)
  );

  // Result stage: holds the result while the registered RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= res.valid;
    end else if (stage_adv) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.kind <= res.kind;
      stage.addr <= res.addr;
      stage.len  <= res.len;
      stage.ok   <= res.ok;
    end
  end

  // Output register: hold until the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= 1'b1;
    end else if (ev.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_kind <= stage.kind;
      out_addr <= stage.addr;
      out_len  <= stage.len;
      out_ok   <= stage.ok;
      out_data <= (stage.kind == EV_READ) ? ram_q : 8'd0;
    end
  end

  assign ev.valid         = out_valid;
  assign ev.event_kind    = out_kind;
  assign ev.slave_address = out_addr;
  assign ev.pdu_length    = out_len;
  assign ev.frame_ok      = out_ok;
  assign ev.read_data     = out_data;

  // A read word reaches the result stage on the next cycle
  a_read_staged: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.action == ACT_READ) |=> (stage.valid && stage.kind == EV_READ))
    else $error("read word lost before result stage");

  // A stalled result stage blocks new input words
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !stage_adv) |-> !rx.ready)
    else $error("input taken while result stage is stalled");

  // The RAM never sees a write and a read in the same cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("frame RAM write and read together");

  // Only read words carry read data
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != EV_READ) |-> (out_data == 8'd0))
    else $error("read data on a non-read word");

endmodule
`default_nettype wire

### rtl/mbrx_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mbrx_ram: simple dual-port synchronous RAM
// One write port, one read port with enable, registered read data.
// ---------------------------------------------------------------------------
module mbrx_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/mbrx_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mbrx_ctrl: receive phase, CRC, byte count and silence timer
// Updates framing state for each accepted word, issues frame store writes
// and reads, and builds the result that goes with the word.
// ---------------------------------------------------------------------------
module mbrx_ctrl
  import mbrx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic       accept,
  input  wire logic [1:0] action,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] read_index,
  output      ram_req_t   ram_req,
  output      res_t       res
);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [15:0]        silence, silence_next;
  logic               timer_running, timer_running_next;
  logic [7:0]         slave_addr, slave_addr_next;
  logic [15:0]        t35_ticks;
  logic [15:0]        sil_inc;
  logic [15:0]        crc_step;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      t35_ticks <= T35_RESET;
    end else if (cfg_we) begin
      t35_ticks <= cfg_data;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_INIT;
      byte_count    <= '0;
      running_crc   <= CRC_INIT;
      silence       <= '0;
      timer_running <= 1'b1;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      silence       <= silence_next;
      timer_running <= timer_running_next;
    end
  end

  // Address byte mirror of store entry zero
  always_ff @(posedge clk) begin
    slave_addr <= slave_addr_next;
  end

  assign sil_inc  = (silence == SIL_MAX) ? SIL_MAX : silence + 16'd1;
  assign crc_step = crc_update((phase == PH_IDLE) ? CRC_INIT : running_crc, rx_byte);

  // Next state, store access and result
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    silence_next       = silence;
    timer_running_next = timer_running;
    slave_addr_next    = slave_addr;
    ram_req            = '0;
    res                = '0;
    res.kind           = EV_BUS_UP;

    if (accept) begin
      unique case (action)
        ACT_BYTE: begin
          unique case (phase)
            PH_IDLE: begin
              ram_req.we       = 1'b1;
              ram_req.waddr    = '0;
              ram_req.wdata    = rx_byte;
              slave_addr_next  = rx_byte;
              byte_count_next  = COUNT_W'(1);
              running_crc_next = crc_step;
              phase_next       = PH_RCV;
            end
            PH_RCV: begin
              if (byte_count < COUNT_W'(FRAME_MAX)) begin
                ram_req.we       = 1'b1;
                ram_req.waddr    = byte_count[STORE_AW-1:0];
                ram_req.wdata    = rx_byte;
                running_crc_next = crc_step;
                byte_count_next  = byte_count + COUNT_W'(1);
              end else begin
                phase_next = PH_ERR;
              end
            end
            default: begin
            end
          endcase
          silence_next       = '0;
          timer_running_next = 1'b1;
        end
        ACT_TICK: begin
          if (timer_running) begin
            if (sil_inc < t35_ticks) begin
              silence_next = sil_inc;
            end else begin
              // Silence expired: stop timer, report what the phase calls for
              timer_running_next = 1'b0;
              silence_next       = '0;
              phase_next         = PH_IDLE;
              if (phase == PH_INIT) begin
                res.valid = 1'b1;
                res.kind  = EV_BUS_UP;
              end else if (phase == PH_RCV) begin
                res.valid = 1'b1;
                res.kind  = EV_FRAME;
                res.addr  = slave_addr;
                if (byte_count >= COUNT_W'(FRAME_MIN)) begin
                  res.len = 8'(byte_count - COUNT_W'(3));
                  res.ok  = (running_crc == 16'd0);
                end
              end
            end
          end
        end
        ACT_READ: begin
          ram_req.re    = 1'b1;
          ram_req.raddr = read_index[STORE_AW-1:0];
          res.valid     = 1'b1;
          res.kind      = EV_READ;
        end
        default: begin
        end
      endcase
    end
  end

  // A frame report only ever follows from the receiving phase
  a_frame_from_rcv: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == EV_FRAME) |-> (phase == PH_RCV))
    else $error("frame report outside receiving phase");

  // Stored bytes never exceed the frame limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(FRAME_MAX))
    else $error("byte count beyond frame limit");

  // Idle phase keeps the timer stopped
  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !timer_running)
    else $error("timer running in idle");

endmodule
`default_nettype wire
